### rtl/stok_pkg.sv
// shared types, constants and byte classifier for the source tokenizer
// depends on nothing; used by every module of the block
package stok_pkg;

    // widths of the record fields
    localparam int KIND_W      = 4;
    localparam int OUT_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int POS_W_DEF   = 16;

    // queue depths between and after the two halves
    localparam int CLS_DEPTH_DEF = 4;
    localparam int REC_DEPTH_DEF = 4;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_ERROR  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd1;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd2;
    localparam logic [KIND_W-1:0] KIND_LBRACK = 4'd3;
    localparam logic [KIND_W-1:0] KIND_RBRACK = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 4'd6;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_LT     = 4'd9;
    localparam logic [KIND_W-1:0] KIND_GT     = 4'd10;
    localparam logic [KIND_W-1:0] KIND_EQ     = 4'd11;
    localparam logic [KIND_W-1:0] KIND_INT    = 4'd12;
    localparam logic [KIND_W-1:0] KIND_FLOAT  = 4'd13;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd14;
    localparam logic [KIND_W-1:0] KIND_SPACE  = 4'd15;

    // character codes
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LA     = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LZ     = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_UA     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UZ     = 8'h5A;

    // one classified source byte
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              fin;
        logic              digit;
        logic              letter;
        logic              space;
        logic              dot;
        logic              newline;
        logic [KIND_W-1:0] punct;
    } t_cls;

    // one token record
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OUT_W-1:0]  line;
        logic [OUT_W-1:0]  col;
        logic [OUT_W-1:0]  len;
        logic [BYTE_W-1:0] bad;
        logic              last;
    } t_rec;

    // punctuation kind of a byte, error kind when it is none
    function automatic logic [KIND_W-1:0] punct_kind(input logic [BYTE_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_COMMA:  k = KIND_COMMA;
            CH_SEMI:   k = KIND_SEMI;
            CH_LT:     k = KIND_LT;
            CH_GT:     k = KIND_GT;
            CH_EQ:     k = KIND_EQ;
            default:   k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // sort a byte into its character classes
    function automatic t_cls classify(input logic [BYTE_W-1:0] c, input logic fin);
        t_cls r;
        r.ch      = c;
        r.fin     = fin;
        r.digit   = (c >= CH_0) && (c <= CH_9);
        r.letter  = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
        r.space   = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
        r.dot     = (c == CH_DOT);
        r.newline = (c == CH_NL);
        r.punct   = punct_kind(c);
        return r;
    endfunction

endpackage

### rtl/stok_front.sv
// front half: classifies incoming bytes and queues them for the scanner
// depends on stok_pkg (t_cls, classify)
module stok_front #(
    parameter int DEPTH = stok_pkg::CLS_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [stok_pkg::BYTE_W-1:0] i_char_byte,
    input  logic                        i_final_char,
    output logic                        o_valid,
    input  logic                        i_take,
    output stok_pkg::t_cls              o_cls
);
    import stok_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls           r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;
    logic           wr_en, rd_en;

    assign full    = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign wr_en   = push && !full;
    assign rd_en   = i_take && o_valid;
    assign o_cls   = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // classified byte storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= classify(i_char_byte, i_final_char);
        end
    end

endmodule

### rtl/stok_scan.sv
// back half: token state machine, turns classified bytes into 0..2 records
// depends on stok_pkg (t_cls, t_rec, kind codes)
module stok_scan #(
    parameter int POS_WIDTH = stok_pkg::POS_W_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  stok_pkg::t_cls i_cls,
    output logic [1:0]     o_wr_n,
    output stok_pkg::t_rec o_rec0,
    output stok_pkg::t_rec o_rec1
);
    import stok_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_FLOAT,
        MODE_IDENT,
        MODE_SPACE,
        MODE_DRAIN
    } t_mode;

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
    localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

    t_mode                r_mode, n_mode;
    logic [POS_WIDTH-1:0] r_cur_line, n_cur_line;
    logic [POS_WIDTH-1:0] r_cur_col,  n_cur_col;
    logic [POS_WIDTH-1:0] r_tok_line, n_tok_line;
    logic [POS_WIDTH-1:0] r_tok_col,  n_tok_col;
    logic [POS_WIDTH-1:0] r_tok_len,  n_tok_len;

    logic [POS_WIDTH-1:0] adv_line, adv_col, len_inc;
    logic                 cont;
    logic                 a_v, b_v;
    t_rec                 rec_a, rec_b;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [KIND_W-1:0] mode_kind(input t_mode m);
        logic [KIND_W-1:0] k;
        case (m)
            MODE_INT:   k = KIND_INT;
            MODE_FLOAT: k = KIND_FLOAT;
            MODE_IDENT: k = KIND_IDENT;
            default:    k = KIND_SPACE;
        endcase
        return k;
    endfunction

    // position after this byte
    assign adv_line = i_cls.newline ? sat_inc(r_cur_line) : r_cur_line;
    assign adv_col  = i_cls.newline ? POS_ONE : sat_inc(r_cur_col);
    assign len_inc  = sat_inc(r_tok_len);

    // scanner next state and records
    always_comb begin
        n_mode     = r_mode;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_tok_len  = r_tok_len;
        cont       = 1'b0;
        a_v        = 1'b0;
        b_v        = 1'b0;
        rec_a      = '0;
        rec_b      = '0;
        if (i_take) begin
            if (r_mode == MODE_DRAIN) begin
                // skip bytes after an error until the text ends
                if (i_cls.fin) begin
                    n_mode     = MODE_IDLE;
                    n_cur_line = POS_ONE;
                    n_cur_col  = POS_ONE;
                    n_tok_line = POS_ONE;
                    n_tok_col  = POS_ONE;
                    n_tok_len  = '0;
                end
            end else begin
                // does the byte extend the open token
                case (r_mode)
                    MODE_INT: begin
                        if (i_cls.digit) begin
                            cont = 1'b1;
                        end else if (i_cls.dot) begin
                            cont   = 1'b1;
                            n_mode = MODE_FLOAT;
                        end
                    end
                    MODE_FLOAT: cont = i_cls.digit;
                    MODE_IDENT: cont = i_cls.letter || i_cls.digit;
                    MODE_SPACE: cont = i_cls.space;
                    default:    cont = 1'b0;
                endcase

                if (cont) begin
                    n_tok_len  = len_inc;
                    n_cur_line = adv_line;
                    n_cur_col  = adv_col;
                    if (i_cls.fin) begin
                        a_v        = 1'b1;
                        rec_a.kind = mode_kind(n_mode);
                        rec_a.line = OUT_W'(r_tok_line);
                        rec_a.col  = OUT_W'(r_tok_col);
                        rec_a.len  = OUT_W'(len_inc);
                        rec_a.last = 1'b1;
                    end
                end else begin
                    // close the open token
                    if (r_mode != MODE_IDLE) begin
                        a_v        = 1'b1;
                        rec_a.kind = mode_kind(r_mode);
                        rec_a.line = OUT_W'(r_tok_line);
                        rec_a.col  = OUT_W'(r_tok_col);
                        rec_a.len  = OUT_W'(r_tok_len);
                        n_mode     = MODE_IDLE;
                    end
                    n_tok_line = r_cur_line;
                    n_tok_col  = r_cur_col;
                    n_tok_len  = POS_ONE;
                    rec_b.line = OUT_W'(r_cur_line);
                    rec_b.col  = OUT_W'(r_cur_col);
                    rec_b.len  = OUT_W'(1);
                    // start a new token from this byte
                    if (i_cls.punct != KIND_ERROR) begin
                        b_v        = 1'b1;
                        rec_b.kind = i_cls.punct;
                        rec_b.last = i_cls.fin;
                    end else if (i_cls.digit) begin
                        n_mode = MODE_INT;
                    end else if (i_cls.letter) begin
                        n_mode = MODE_IDENT;
                    end else if (i_cls.space) begin
                        n_mode = MODE_SPACE;
                    end else begin
                        b_v        = 1'b1;
                        rec_b.kind = KIND_ERROR;
                        rec_b.bad  = i_cls.ch;
                        rec_b.last = i_cls.fin;
                        n_mode     = MODE_DRAIN;
                    end
                    n_cur_line = adv_line;
                    n_cur_col  = adv_col;
                    // a one-byte token closed by the end of text
                    if (i_cls.fin && (n_mode == MODE_INT || n_mode == MODE_IDENT
                                      || n_mode == MODE_SPACE)) begin
                        b_v        = 1'b1;
                        rec_b.kind = mode_kind(n_mode);
                        rec_b.last = 1'b1;
                    end
                end

                if (i_cls.fin) begin
                    n_mode     = MODE_IDLE;
                    n_cur_line = POS_ONE;
                    n_cur_col  = POS_ONE;
                    n_tok_line = POS_ONE;
                    n_tok_col  = POS_ONE;
                    n_tok_len  = '0;
                end
            end
        end
    end

    // pack records toward slot 0
    assign o_wr_n = {1'b0, a_v} + {1'b0, b_v};
    assign o_rec0 = a_v ? rec_a : rec_b;
    assign o_rec1 = rec_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_cur_line <= POS_ONE;
            r_cur_col  <= POS_ONE;
            r_tok_line <= POS_ONE;
            r_tok_col  <= POS_ONE;
            r_tok_len  <= '0;
        end else begin
            r_mode     <= n_mode;
            r_cur_line <= n_cur_line;
            r_cur_col  <= n_cur_col;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_tok_len  <= n_tok_len;
        end
    end

endmodule

### rtl/stok_rec_fifo.sv
// result queue: takes up to two records a cycle, hands out one per beat
// depends on stok_pkg (t_rec)
module stok_rec_fifo #(
    parameter int DEPTH = stok_pkg::REC_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_wr_n,
    input  stok_pkg::t_rec i_rec0,
    input  stok_pkg::t_rec i_rec1,
    output logic           o_room2,
    output logic           empty,
    input  logic           pop,
    output stok_pkg::t_rec o_rec
);
    import stok_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_rec           r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [AW-1:0]  wr_ptr1;
    logic [CW-1:0]  r_count;
    logic           rd_en;

    assign empty   = (r_count == '0);
    assign rd_en   = pop && !empty;
    assign o_rec   = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    // pointers and fill count, depth is a power of two so pointers wrap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(i_wr_n);
            r_rd_ptr <= r_rd_ptr + AW'(rd_en);
            r_count  <= r_count + CW'(i_wr_n) - CW'(rd_en);
        end
    end

    // record storage
    always_ff @(posedge i_clk) begin
        if (i_wr_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_rec0;
        end
        if (i_wr_n == 2'd2) begin
            r_mem[wr_ptr1] <= i_rec1;
        end
    end

endmodule

### rtl/source_tokenizer.sv
// top level of the source tokenizer: byte queue, scanner, record queue
// depends on stok_pkg, stok_front, stok_scan, stok_rec_fifo
//
//  channel  | handshake           | beat
//  ---------+---------------------+---------------------------------------------
//  bytes in | push / full         | i_char_byte, i_final_char
//  records  | empty / pop         | o_token_kind, o_start_line, o_start_col,
//           |                     | o_token_length, o_bad_byte, o_stream_end
//
// One byte is taken per cycle; a byte's records become visible only after it has
// passed the byte queue and then the record queue, both registered, and a run
// token's record waits for the byte that closes it.
// The scanner takes a byte only while the record queue has room for two
// records, so a slow or stalled reader backs up through both queues to full.
// Records leave at one per pop, which bounds the rate when bytes end tokens.
// Reset returns line and column to 1 and empties both queues.
module source_tokenizer #(
    parameter int POS_WIDTH = stok_pkg::POS_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [stok_pkg::BYTE_W-1:0] i_char_byte,
    input  logic                        i_final_char,
    output logic                        empty,
    input  logic                        pop,
    output logic [stok_pkg::KIND_W-1:0] o_token_kind,
    output logic [stok_pkg::OUT_W-1:0]  o_start_line,
    output logic [stok_pkg::OUT_W-1:0]  o_start_col,
    output logic [stok_pkg::OUT_W-1:0]  o_token_length,
    output logic [stok_pkg::BYTE_W-1:0] o_bad_byte,
    output logic                        o_stream_end
);
    import stok_pkg::*;

    t_cls       cls;
    logic       cls_valid;
    logic       room2;
    logic       take;
    logic [1:0] wr_n;
    t_rec       rec0, rec1, rec_out;

    // scanner moves when a byte waits and the record queue can take two
    assign take = cls_valid && room2;

    stok_front #(
        .DEPTH        (CLS_DEPTH_DEF)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_char_byte  (i_char_byte),
        .i_final_char (i_final_char),
        .o_valid      (cls_valid),
        .i_take       (take),
        .o_cls        (cls)
    );

    stok_scan #(
        .POS_WIDTH    (POS_WIDTH)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_cls        (cls),
        .o_wr_n       (wr_n),
        .o_rec0       (rec0),
        .o_rec1       (rec1)
    );

    stok_rec_fifo #(
        .DEPTH        (REC_DEPTH_DEF)
    ) u_rec_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_n       (wr_n),
        .i_rec0       (rec0),
        .i_rec1       (rec1),
        .o_room2      (room2),
        .empty        (empty),
        .pop          (pop),
        .o_rec        (rec_out)
    );

    // record fields onto the ports
    assign o_token_kind   = rec_out.kind;
    assign o_start_line   = rec_out.line;
    assign o_start_col    = rec_out.col;
    assign o_token_length = rec_out.len;
    assign o_bad_byte     = rec_out.bad;
    assign o_stream_end   = rec_out.last;

endmodule
